/* hdl/set_assoc_cache_tag_controller_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache tag controller
// Short forms for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SACT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SACT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sact_pkg.sv */
// ----------------------------------------------------------------------------
// sact_pkg
// Types, constants and helper functions shared by the cache tag controller.
// ----------------------------------------------------------------------------
package sact_pkg;

    // Width of the address field on the request channel.
    localparam int ADDR_W = 40;
    // Width of the saturating hit and miss counters.
    localparam int CNT_W = 32;
    // Width of the way field on the response channel.
    localparam int WAY_OUT_W = 3;
    // Victim selection LFSR.
    localparam int LFSR_W = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ACT_READ_HIT   = 2'd0,
        ACT_WRITE_HIT  = 2'd1,
        ACT_READ_FILL  = 2'd2,
        ACT_WRITE_MISS = 2'd3
    } t_action;

    // Floor of log2, evaluated at elaboration only.
    function automatic int floor_log2(input int v);
        int r;
        int x;
        r = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            r = r + 1;
        end
        return r;
    endfunction

    // One step of the Fibonacci LFSR with taps 16, 14, 13 and 11.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[LFSR_W-1:1]};
    endfunction

endpackage

/* hdl/sact_intf.sv */
// ----------------------------------------------------------------------------
// Cache tag controller channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sact_req_if;
    logic                        valid;
    logic                        ready;
    logic [sact_pkg::ADDR_W-1:0] address;
    logic                        mode;

    modport source (output valid, output address, output mode, input ready);
    modport sink   (input valid, input address, input mode, output ready);
endinterface

interface sact_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    sact_pkg::t_action              action;
    logic [sact_pkg::WAY_OUT_W-1:0] way;
    logic [sact_pkg::CNT_W-1:0]     hits_seen;
    logic [sact_pkg::CNT_W-1:0]     misses_seen;

    modport source (output valid, output hit, output action, output way,
                    output hits_seen, output misses_seen, input ready);
    modport sink   (input valid, input hit, input action, input way,
                    input hits_seen, input misses_seen, output ready);
endinterface

/* hdl/sact_ram.sv */
// ----------------------------------------------------------------------------
// sact_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/set_assoc_cache_tag_controller.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Tag and valid store of a set-associative, write-through cache with
// random replacement and saturating hit and miss counters.
// ----------------------------------------------------------------------------
// Usage: accesses arrive on i_req (address, mode) as words under a valid/ready
// handshake, and one response word per access leaves on o_rsp (hit, action,
// way, hits_seen, misses_seen) in the same order.
// Pipeline: an accepted word passes the lookup stage and then the response
// register. Throughput is one access per cycle while o_rsp.ready does not
// stall: the single read port of the tag RAM is read at acceptance and the
// set row is written back when the access leaves the lookup stage; a fill
// to the set that the next access reads is forwarded from a register, not the RAM.
// Reset: the tag RAM is swept clean one set row per cycle, and i_req.ready
// stays low until the sweep is done. The LFSR restarts from its seed and
// both counters clear.
// Stall: while o_rsp.ready is low the response register holds its word, an
// access in the lookup stage waits, and no request word is taken behind it.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_controller_macros.svh"

module set_assoc_cache_tag_controller #(
    parameter int NUM_SETS   = 64,
    parameter int WAYS       = 8,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 40
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sact_req_if.sink        i_req,
    sact_rsp_if.source      o_rsp
);

    // ------------------------------------------------------------------
    // Derived geometry. Only the lower power-of-two count of sets is ever
    // addressed, and the address is limited to ADDR_BITS bits.
    // ------------------------------------------------------------------
    localparam int AW      = sact_pkg::ADDR_W;
    localparam int LW      = sact_pkg::LFSR_W;
    localparam int OFF_W   = sact_pkg::floor_log2(LINE_BYTES);
    localparam int IDX_W   = sact_pkg::floor_log2(NUM_SETS);
    localparam int SET_AW  = (IDX_W > 0) ? IDX_W : 1;
    localparam int SET_NUM = 1 << IDX_W;
    localparam int ABITS   = (ADDR_BITS < AW) ? ADDR_BITS : AW;
    localparam int TAG_RAW = ABITS - OFF_W - IDX_W;
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W   = WAYS * (TAG_W + 1);

    localparam logic [AW-1:0] ADDR_MASK = AW'((64'd1 << ABITS) - 64'd1);
    localparam logic [AW-1:0] IDX_MASK  = AW'((64'd1 << IDX_W) - 64'd1);
    localparam logic [SET_AW-1:0] LAST_SET = SET_AW'(SET_NUM - 1);

    // The victim is the new LFSR value modulo WAYS, taken through an exact
    // reciprocal multiply: q = (x * MOD_M) >> MOD_SH.
    localparam int MOD_SH = LW + ((WAYS > 1) ? $clog2(WAYS) : 0);
    localparam int MOD_MW = LW + 2;
    localparam int PROD_W = LW + MOD_MW;
    localparam logic [MOD_MW-1:0] MOD_M =
        MOD_MW'(((64'd1 << MOD_SH) + 64'(WAYS) - 64'd1) / 64'(WAYS));
    localparam logic [LW-1:0] WAYS_L = LW'(WAYS);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic                         r_clearing;
    logic [SET_AW-1:0]            r_clr_idx;
    logic                         r_s1_valid;
    logic [SET_AW-1:0]            r_s1_idx;
    logic [TAG_W-1:0]             r_s1_tag;
    logic                         r_s1_mode;
    logic                         r_fwd_use;
    logic [ROW_W-1:0]             r_fwd_row;
    logic [LW-1:0]                r_lfsr;
    logic [sact_pkg::CNT_W-1:0]   r_hit_cnt;
    logic [sact_pkg::CNT_W-1:0]   r_miss_cnt;
    logic                         r_out_valid;
    logic                         r_out_hit;
    sact_pkg::t_action            r_out_action;
    logic [sact_pkg::WAY_OUT_W-1:0] r_out_way;

    logic [LW-1:0]                n_lfsr;
    logic [sact_pkg::CNT_W-1:0]   n_hit_cnt;
    logic [sact_pkg::CNT_W-1:0]   n_miss_cnt;
    sact_pkg::t_action            n_action;
    logic [sact_pkg::WAY_OUT_W-1:0] n_way;

    // ------------------------------------------------------------------
    // Request side: address split and handshake
    // ------------------------------------------------------------------
    logic [AW-1:0]     addr_lim;
    logic [SET_AW-1:0] in_idx;
    logic [TAG_W-1:0]  in_tag;
    logic              in_accept;
    logic              s1_go;

    assign addr_lim = i_req.address & ADDR_MASK;
    assign in_idx   = SET_AW'((addr_lim >> OFF_W) & IDX_MASK);
    assign in_tag   = TAG_W'(addr_lim >> (OFF_W + IDX_W));

    // The lookup stage retires whenever the response register is free or
    // is being emptied in this cycle.
    assign s1_go       = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_clearing && (!r_s1_valid || s1_go);
    assign in_accept   = i_req.valid && i_req.ready;

    // ------------------------------------------------------------------
    // Tag RAM: one row per set, valid bits above the packed tags.
    // While the lookup stage waits, its own set is read again so that the
    // read data stays current.
    // ------------------------------------------------------------------
    logic              ram_we;
    logic              fill_we;
    logic [SET_AW-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [SET_AW-1:0] ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;
    logic [ROW_W-1:0]  fill_row;

    assign ram_raddr = i_req.ready ? in_idx : r_s1_idx;
    assign ram_we    = r_clearing || fill_we;
    assign ram_waddr = r_clearing ? r_clr_idx : r_s1_idx;
    assign ram_wdata = r_clearing ? '0 : fill_row;

    sact_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_NUM)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Lookup stage: compare all ways, pick hit way or fill way.
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] cur_row;
    logic [WAYS-1:0]  way_valid;
    logic [WAYS-1:0]  way_match;
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             free_found;
    logic [WAY_W-1:0] free_way;
    logic             read_miss;
    logic [WAY_W-1:0] fill_way;
    logic [LW-1:0]    lfsr_nx;
    logic [PROD_W-1:0] mod_prod;
    logic [LW-1:0]    mod_quot;
    logic [LW-1:0]    mod_rem;
    logic [WAY_W-1:0] victim;

    // The row written back in the previous cycle is not yet visible in the
    // read data when the next access targets the same set.
    assign cur_row = r_fwd_use ? r_fwd_row : ram_rdata;

    always_comb begin
        way_match  = '0;
        way_valid  = '0;
        hit_way    = '0;
        free_way   = '0;
        for (int w = 0; w < WAYS; w++) begin
            way_valid[w] = cur_row[WAYS * TAG_W + w];
            way_match[w] = way_valid[w] && (cur_row[w * TAG_W +: TAG_W] == r_s1_tag);
        end
        // Lowest-numbered way wins in both searches.
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (way_match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (!way_valid[w]) begin
                free_way = WAY_W'(w);
            end
        end
    end

    assign hit        = |way_match;
    assign free_found = !(&way_valid);
    assign read_miss  = !hit && (r_s1_mode == sact_pkg::MODE_READ);

    assign lfsr_nx  = sact_pkg::lfsr_step(r_lfsr);
    assign mod_prod = PROD_W'(lfsr_nx) * PROD_W'(MOD_M);
    assign mod_quot = LW'(mod_prod >> MOD_SH);
    assign mod_rem  = lfsr_nx - LW'(mod_quot * WAYS_L);
    assign victim   = WAY_W'(mod_rem);

    assign fill_way = free_found ? free_way : victim;
    assign fill_we  = s1_go && read_miss;

    always_comb begin
        fill_row = cur_row;
        for (int w = 0; w < WAYS; w++) begin
            if (fill_way == WAY_W'(w)) begin
                fill_row[w * TAG_W +: TAG_W] = r_s1_tag;
                fill_row[WAYS * TAG_W + w]   = 1'b1;
            end
        end
    end

    // Response fields and state updates of a retiring access.
    always_comb begin
        n_lfsr     = r_lfsr;
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (hit) begin
            n_way = sact_pkg::WAY_OUT_W'(hit_way);
            if (r_s1_mode == sact_pkg::MODE_WRITE) begin
                n_action = sact_pkg::ACT_WRITE_HIT;
            end else begin
                n_action = sact_pkg::ACT_READ_HIT;
            end
        end else if (r_s1_mode == sact_pkg::MODE_WRITE) begin
            n_way    = '0;
            n_action = sact_pkg::ACT_WRITE_MISS;
        end else begin
            n_way    = sact_pkg::WAY_OUT_W'(fill_way);
            n_action = sact_pkg::ACT_READ_FILL;
        end
        if (s1_go) begin
            if (hit) begin
                if (r_hit_cnt != '1) begin
                    n_hit_cnt = r_hit_cnt + 1'b1;
                end
            end else if (r_miss_cnt != '1) begin
                n_miss_cnt = r_miss_cnt + 1'b1;
            end
            // The LFSR moves only when a read miss finds the set full.
            if (read_miss && !free_found) begin
                n_lfsr = lfsr_nx;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_use   <= 1'b0;
            r_out_valid <= 1'b0;
            r_lfsr      <= sact_pkg::LFSR_SEED;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_SET) begin
                    r_clearing <= 1'b0;
                end
            end

            if (i_req.ready) begin
                r_s1_valid <= in_accept;
            end

            r_fwd_use <= fill_we && in_accept && (in_idx == r_s1_idx);

            r_lfsr     <= n_lfsr;
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;

            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // Payload registers.
        if (in_accept) begin
            r_s1_idx  <= in_idx;
            r_s1_tag  <= in_tag;
            r_s1_mode <= i_req.mode;
        end
        r_fwd_row <= fill_row;
        if (s1_go) begin
            r_out_hit    <= hit;
            r_out_action <= n_action;
            r_out_way    <= n_way;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.action      = r_out_action;
    assign o_rsp.way         = r_out_way;
    assign o_rsp.hits_seen   = r_hit_cnt;
    assign o_rsp.misses_seen = r_miss_cnt;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SACT_ASSERT_NEXT(a_stage_reaches_out, i_rst_n && r_s1_valid && !r_out_valid,
        r_out_valid, "lookup result did not reach the response register")

    `SACT_ASSERT_NOW(a_hit_matches_action, r_out_valid,
        r_out_hit == (r_out_action == sact_pkg::ACT_READ_HIT ||
                      r_out_action == sact_pkg::ACT_WRITE_HIT),
        "hit flag disagrees with action code")

    `SACT_ASSERT_NOW(a_write_miss_way_zero,
        r_out_valid && r_out_action == sact_pkg::ACT_WRITE_MISS,
        r_out_way == '0, "write miss reported a nonzero way")

    `SACT_ASSERT_NOW(a_lfsr_nonzero, 1'b1, r_lfsr != '0,
        "victim LFSR reached the all-zero lockup state")

    `SACT_ASSERT_NEXT(a_counters_monotonic, i_rst_n,
        r_hit_cnt >= $past(r_hit_cnt) && r_miss_cnt >= $past(r_miss_cnt),
        "hit or miss counter decreased")

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: cache tag controller testbench
// Sends read and write accesses to the tag controller and checks every
// response word against a cycle-free model of the tag store. The model covers
// the tag and valid bits, victim selection and the saturating counters.
// ----------------------------------------------------------------------------
module tb_top;

    // Geometry of the block under test. All of these are powers of two, so
    // the clog2 split below matches the block's floor-of-log2 split.
    localparam int NUM_SETS   = 64;
    localparam int WAYS       = 8;
    localparam int LINE_BYTES = 64;
    localparam int OFF_BITS   = $clog2(LINE_BYTES);
    localparam int IDX_BITS   = $clog2(NUM_SETS);
    localparam int ADDR_W     = sact_pkg::ADDR_W;
    localparam int TAG_W      = ADDR_W - OFF_BITS - IDX_BITS;
    localparam int WAY_OUT_W  = sact_pkg::WAY_OUT_W;
    localparam int CNT_W      = sact_pkg::CNT_W;
    localparam int LFSR_W     = sact_pkg::LFSR_W;

    // Stimulus size and run limits.
    localparam int RANDOM_ACCESSES = 1350;
    localparam int QUIET_TAIL      = 150;  // last accesses run with no idling
    localparam int LONG_HOLD       = 120;  // cycles of the long receiver stall
    localparam int HOLD_AFTER      = 400;  // responses checked before that stall
    localparam int STALL_LIMIT     = 1000; // cycles with no word moving at all
    localparam int MAX_PRINTED     = 40;

    // Expected content of one response word.
    typedef struct packed {
        logic                 hit;
        sact_pkg::t_action    action;
        logic [WAY_OUT_W-1:0] way;
        logic [CNT_W-1:0]     hits_seen;
        logic [CNT_W-1:0]     misses_seen;
    } t_lookup_result;

    // ------------------------------------------------------------------------
    // Tag store model and response checker. Each accepted access updates the
    // model at once and queues the response word it must produce; responses
    // are then matched in order against that queue.
    // ------------------------------------------------------------------------
    class tag_lookup_predictor;
        logic [TAG_W-1:0]  tag_mem   [NUM_SETS*WAYS];
        logic              valid_mem [NUM_SETS*WAYS];
        logic [LFSR_W-1:0] victim_lfsr;
        logic [CNT_W-1:0]  hit_count;
        logic [CNT_W-1:0]  miss_count;
        t_lookup_result    outstanding[$];
        int                errors;
        int                checked;
        int                n_read_hit;
        int                n_write_hit;
        int                n_fill;
        int                n_evict;
        int                n_write_miss;

        function new();
            foreach (tag_mem[i]) begin
                tag_mem[i]   = '0;
                valid_mem[i] = 1'b0;
            end
            victim_lfsr = sact_pkg::LFSR_SEED;
            hit_count   = '0;
            miss_count  = '0;
            errors      = 0;
            checked     = 0;
            n_read_hit  = 0;
            n_write_hit = 0;
            n_fill      = 0;
            n_evict     = 0;
            n_write_miss = 0;
        endfunction

        function int pending();
            return outstanding.size();
        endfunction

        task report(input string what);
            if (errors < MAX_PRINTED)
                $display("[%0t] tag lookup mismatch: %s", $time, what);
            errors++;
        endtask

        // Look the access up in the model, apply its side effects and queue
        // the response word that the block owes for it.
        function void note_access(input logic [ADDR_W-1:0] addr, input logic mode);
            t_lookup_result   want;
            logic [TAG_W-1:0] tag;
            int               base;
            int               victim;
            bit               found;

            tag    = addr[ADDR_W-1 -: TAG_W];
            base   = int'(addr[OFF_BITS +: IDX_BITS]) * WAYS;
            found  = 1'b0;
            victim = 0;
            // The lowest matching valid way wins.
            for (int w = 0; w < WAYS; w++) begin
                if (!found && valid_mem[base + w] && tag_mem[base + w] == tag) begin
                    found  = 1'b1;
                    victim = w;
                end
            end
            want.hit = found;
            if (found) begin
                if (hit_count != '1)
                    hit_count++;
                want.action = (mode == sact_pkg::MODE_WRITE) ? sact_pkg::ACT_WRITE_HIT
                                                             : sact_pkg::ACT_READ_HIT;
                if (mode == sact_pkg::MODE_WRITE)
                    n_write_hit++;
                else
                    n_read_hit++;
            end else begin
                if (miss_count != '1)
                    miss_count++;
                if (mode == sact_pkg::MODE_WRITE) begin
                    // Write-through with no allocation: the tags stay as they are.
                    want.action = sact_pkg::ACT_WRITE_MISS;
                    victim      = 0;
                    n_write_miss++;
                end else begin
                    want.action = sact_pkg::ACT_READ_FILL;
                    for (int w = WAYS - 1; w >= 0; w--) begin
                        if (!valid_mem[base + w]) begin
                            found  = 1'b1;
                            victim = w;
                        end
                    end
                    // A full set steps the LFSR once and takes its new value
                    // modulo the number of ways as the victim.
                    if (!found) begin
                        victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3]
                                       ^ victim_lfsr[5], victim_lfsr[LFSR_W-1:1]};
                        victim = int'(victim_lfsr) % WAYS;
                        n_evict++;
                    end
                    tag_mem[base + victim]   = tag;
                    valid_mem[base + victim] = 1'b1;
                    n_fill++;
                end
            end
            want.way         = victim[WAY_OUT_W-1:0];
            want.hits_seen   = hit_count;
            want.misses_seen = miss_count;
            outstanding.push_back(want);
        endfunction

        task check_response(input logic hit, input sact_pkg::t_action action,
                            input logic [WAY_OUT_W-1:0] way,
                            input logic [CNT_W-1:0] hits_seen,
                            input logic [CNT_W-1:0] misses_seen);
            t_lookup_result want;
            if (outstanding.size() == 0) begin
                report("response word with no access outstanding");
            end else begin
                want = outstanding.pop_front();
                checked++;
                if (hit !== want.hit)
                    report($sformatf("word %0d hit %b, expected %b", checked, hit, want.hit));
                if (action !== want.action)
                    report($sformatf("word %0d action %0d, expected %0d",
                                     checked, action, want.action));
                if (way !== want.way)
                    report($sformatf("word %0d way %0d, expected %0d", checked, way, want.way));
                if (hits_seen !== want.hits_seen)
                    report($sformatf("word %0d hits_seen %0d, expected %0d",
                                     checked, hits_seen, want.hits_seen));
                if (misses_seen !== want.misses_seen)
                    report($sformatf("word %0d misses_seen %0d, expected %0d",
                                     checked, misses_seen, want.misses_seen));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    sact_req_if req_ch ();
    sact_rsp_if rsp_ch ();

    set_assoc_cache_tag_controller #(
        .NUM_SETS   (NUM_SETS),
        .WAYS       (WAYS),
        .LINE_BYTES (LINE_BYTES),
        .ADDR_BITS  (ADDR_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    tag_lookup_predictor lookups = new();

    // Idling controls, written only by the stimulus process.
    bit sender_idles   = 1'b0;
    bit receiver_idles = 1'b0;
    bit quiet_tail     = 1'b0;

    // A small pool of tags per run. Twelve tags compete for eight ways in
    // the busy sets, so hits, fills and evictions all happen often.
    logic [TAG_W-1:0] tag_pool [12];

    // 20 time unit clock.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Byte address in a given line, with a random offset inside the line.
    function automatic logic [ADDR_W-1:0] line_address(input logic [TAG_W-1:0] tag,
                                                       input int set);
        return {tag, IDX_BITS'(set), OFF_BITS'($urandom_range(0, LINE_BYTES - 1))};
    endfunction

    // Random address for the bulk of the run. Half of the accesses go to a few
    // busy sets with pooled tags so that lines get reused and evicted; the rest
    // spread over all sets, over the whole address space, or hit the ends.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [63:0] wide;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (pick < 15)
            return wide[ADDR_W-1:0];
        else if (pick < 20)
            return $urandom_range(0, 1) ? '1 : '0;
        else if (pick < 70)
            return line_address(tag_pool[$urandom_range(0, 11)],
                                $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                     : $urandom_range(NUM_SETS - 2,
                                                                      NUM_SETS - 1));
        else
            return line_address(tag_pool[$urandom_range(0, 5)],
                                $urandom_range(0, NUM_SETS - 1));
    endfunction

    // Offer one access word and hold it until the block takes it. The word
    // is recorded in the model at the edge where the handshake completes.
    // Afterwards the sender may idle for a short burst, with junk on the
    // payload lines so that nothing leaks through while valid is low.
    task automatic send_access(input logic [ADDR_W-1:0] addr, input logic mode);
        req_ch.valid   = 1'b1;
        req_ch.address = addr;
        req_ch.mode    = mode;
        do @(posedge i_clk); while (!req_ch.ready);
        lookups.note_access(addr, mode);
        @(negedge i_clk);
        if (sender_idles && !quiet_tail && $urandom_range(0, 3) == 0) begin
            req_ch.valid   = 1'b0;
            req_ch.address = ADDR_W'({$urandom, $urandom});
            req_ch.mode    = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    // Response receiver. Ready drops in short random bursts while idling is
    // on, and once, after a few hundred responses, for a long stretch so
    // that the lookup pipeline fills up and pushes back on the sender.
    initial begin
        bit long_hold_done;
        long_hold_done = 1'b0;
        rsp_ch.ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                rsp_ch.ready = 1'b0;
            end else if (!long_hold_done && lookups.checked >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                rsp_ch.ready   = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (receiver_idles && !quiet_tail && $urandom_range(0, 4) == 0) begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge i_clk);
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // Every response word that the block hands over is checked at once.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
            lookups.check_response(rsp_ch.hit, rsp_ch.action, rsp_ch.way,
                                   rsp_ch.hits_seen, rsp_ch.misses_seen);
    end

    // Watchdog: the run fails if no word moves on either channel for too
    // long. The limit covers the reset sweep of the tag RAM and the long
    // receiver stall with a wide margin.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid === 1'b1 && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Main stimulus.
    initial begin
        req_ch.valid   = 1'b0;
        req_ch.address = '0;
        req_ch.mode    = sact_pkg::MODE_READ;
        i_rst_n        = 1'b0;

        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 12; i++)
            tag_pool[i] = TAG_W'($urandom);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Tag zero must miss after reset, since every way
        // starts invalid even though the stored tags are zero.
        send_access('0, sact_pkg::MODE_READ);
        send_access(line_address('0, 0), sact_pkg::MODE_READ);
        send_access(line_address('0, 0), sact_pkg::MODE_WRITE);
        // A write miss goes to memory only, so the read after it still misses.
        send_access(40'h12_3456_7890, sact_pkg::MODE_WRITE);
        send_access(40'h12_3456_7890, sact_pkg::MODE_READ);
        // Highest address, then a line with an all-ones tag in set zero.
        send_access('1, sact_pkg::MODE_READ);
        send_access('1, sact_pkg::MODE_WRITE);
        send_access(line_address('1, 0), sact_pkg::MODE_READ);
        // Fill every way of one set, then overflow it so that the LFSR picks
        // a victim; the reads after that find out which line was evicted.
        for (int t = 1; t <= WAYS + 1; t++)
            send_access(line_address(TAG_W'(t), 5), sact_pkg::MODE_READ);
        send_access(line_address(TAG_W'(WAYS + 1), 5), sact_pkg::MODE_READ);
        send_access(line_address(TAG_W'(1), 5), sact_pkg::MODE_READ);
        send_access(line_address(TAG_W'(2), 5), sact_pkg::MODE_READ);
        send_access(line_address(TAG_W'(3), 5), sact_pkg::MODE_WRITE);
        send_access(40'h80_0000_0000, sact_pkg::MODE_READ);
        send_access(40'hAA_AAAA_AAAA, sact_pkg::MODE_READ);
        send_access(40'h55_5555_5555, sact_pkg::MODE_WRITE);

        // Random part, in segments that switch idling on and off on each
        // side independently; the tail runs at full rate.
        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            if (n % 50 == 0) begin
                sender_idles   = $urandom_range(0, 2) != 0;
                receiver_idles = $urandom_range(0, 2) != 0;
            end
            if (n == RANDOM_ACCESSES - QUIET_TAIL)
                quiet_tail = 1'b1;
            send_access(pick_address(),
                        ($urandom_range(0, 99) < 65) ? sact_pkg::MODE_READ
                                                     : sact_pkg::MODE_WRITE);
        end
        req_ch.valid = 1'b0;

        // Drain the outstanding responses, then give the block a few more
        // cycles in case it emits a word nobody asked for.
        while (lookups.pending() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Checked %0d responses: %0d read hits, %0d write hits, %0d write misses.",
                 lookups.checked, lookups.n_read_hit, lookups.n_write_hit,
                 lookups.n_write_miss);
        $display("Read misses filled %0d lines, %0d of them by evicting from a full set.",
                 lookups.n_fill, lookups.n_evict);
        if (lookups.errors == 0 && lookups.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d responses missing", lookups.errors,
                     lookups.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* set_assoc_cache_tag_controller.f */
+incdir+hdl
hdl/sact_pkg.sv
hdl/sact_intf.sv
hdl/sact_ram.sv
hdl/set_assoc_cache_tag_controller.sv
tb/tb_top.sv
